// ===== design/ordered_set_table_top_macros.svh =====
// Assertion macros for the ordered set table.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef ORDERED_SET_TABLE_TOP_MACROS_SVH
`define ORDERED_SET_TABLE_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define OST_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("ost assertion failed");

`define OST_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ost assertion failed");

`else

`define OST_ASSERT(label, cond)

`define OST_ASSERT_IMP(label, ante, cons)

`endif

`endif

// ===== design/ost_pkg.sv =====
package ost_pkg;

  localparam int CAPACITY   = 64;
  localparam int ELEM_WIDTH = 32;
  localparam int ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int KIND_W     = 2;
  localparam int IN_W       = 32;
  localparam int OUT_CNT_W  = 7;

  typedef logic [ELEM_WIDTH-1:0] elem_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_SEARCH = 2'd2
  } kind_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic walk_run;
    logic apply;
    logic shift_start;
    logic shrink;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic match;
    logic walk_idle;
    logic need_shift;
    cnt_t count;
  } stat_t;

  function automatic elem_t to_elem(logic [IN_W-1:0] x);
    logic [63:0] ext;
    ext = {{(64 - IN_W){x[IN_W-1]}}, x};
    return ext[ELEM_WIDTH-1:0];
  endfunction

  function automatic logic [OUT_CNT_W-1:0] cnt_out(cnt_t c);
    logic [63:0] t;
    t = 64'(c);
    return t[OUT_CNT_W-1:0];
  endfunction

endpackage

// ===== design/ost_dp.sv =====
module ost_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ost_pkg::cmd_t                 cmd,
  input  logic [ost_pkg::KIND_W-1:0]    in_kind,
  input  logic signed [ost_pkg::IN_W-1:0] in_elem_value,
  output ost_pkg::stat_t                st,
  output logic                          out_success,
  output logic                          out_full_reject,
  output logic [ost_pkg::OUT_CNT_W-1:0] out_entry_count,
  output logic                          out_is_empty
);
  import ost_pkg::*;

  elem_t                mem [CAPACITY];
  elem_t                rd_data_r;

  elem_t                val_r, val_nxt;
  logic [KIND_W-1:0]    kind_r, kind_nxt;
  cnt_t                 count_r, count_nxt;
  logic                 hit_r, hit_nxt;
  cnt_t                 pos_r, pos_nxt;
  logic                 ok_r, ok_nxt;
  logic                 full_r, full_nxt;
  cnt_t                 walk_idx_r, walk_idx_nxt;
  logic                 pend_r, pend_nxt;
  cnt_t                 pend_idx_r, pend_idx_nxt;
  logic                 shift_mode_r, shift_mode_nxt;

  logic                 succ_r, rej_r, empty_r;
  logic [OUT_CNT_W-1:0] ecount_r;

  logic                 more;
  logic                 issue;
  logic                 is_full;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_wa;
  elem_t                mem_wd;
  cnt_t                 dst_idx;

  assign more    = walk_idx_r < count_r;
  assign issue   = cmd.walk_run && more;
  assign is_full = count_r == CNT_W'(CAPACITY);
  assign dst_idx = pend_idx_r - 1'b1;

  assign st.match      = cmd.walk_run && !shift_mode_r && pend_r && (rd_data_r == val_r);
  assign st.walk_idle  = !more && !pend_r;
  assign st.need_shift = (kind_r == KIND_REMOVE) && hit_r;
  assign st.count      = count_r;

  always_comb begin
    val_nxt        = val_r;
    kind_nxt       = kind_r;
    count_nxt      = count_r;
    hit_nxt        = hit_r;
    pos_nxt        = pos_r;
    ok_nxt         = ok_r;
    full_nxt       = full_r;
    walk_idx_nxt   = walk_idx_r;
    pend_nxt       = issue;
    pend_idx_nxt   = issue ? walk_idx_r : pend_idx_r;
    shift_mode_nxt = shift_mode_r;
    mem_we         = 1'b0;
    mem_wa         = dst_idx[ADDR_W-1:0];
    mem_wd         = rd_data_r;

    if (issue) begin
      walk_idx_nxt = walk_idx_r + 1'b1;
    end

    if (cmd.load) begin
      val_nxt  = to_elem(in_elem_value);
      kind_nxt = in_kind;
      hit_nxt  = 1'b0;
      ok_nxt   = 1'b0;
      full_nxt = 1'b0;
    end

    if (cmd.scan_start) begin
      walk_idx_nxt   = '0;
      pend_nxt       = 1'b0;
      shift_mode_nxt = 1'b0;
    end

    if (st.match) begin
      hit_nxt = 1'b1;
      pos_nxt = pend_idx_r;
    end

    if (cmd.walk_run && shift_mode_r && pend_r) begin
      mem_we = 1'b1;
    end

    if (cmd.apply) begin
      case (kind_r)
        KIND_ADD: begin
          if (!hit_r) begin
            if (is_full) begin
              full_nxt = 1'b1;
            end else begin
              mem_we    = 1'b1;
              mem_wa    = count_r[ADDR_W-1:0];
              mem_wd    = val_r;
              count_nxt = count_r + 1'b1;
              ok_nxt    = 1'b1;
            end
          end
        end
        KIND_REMOVE: ok_nxt = hit_r;
        KIND_SEARCH: ok_nxt = hit_r;
        default:     ok_nxt = 1'b0;
      endcase
    end

    if (cmd.shift_start) begin
      walk_idx_nxt   = pos_r + 1'b1;
      pend_nxt       = 1'b0;
      shift_mode_nxt = 1'b1;
    end

    if (cmd.shrink) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[walk_idx_r[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      pend_r       <= 1'b0;
      shift_mode_r <= 1'b0;
      walk_idx_r   <= '0;
    end else begin
      count_r      <= count_nxt;
      pend_r       <= pend_nxt;
      shift_mode_r <= shift_mode_nxt;
      walk_idx_r   <= walk_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    kind_r     <= kind_nxt;
    hit_r      <= hit_nxt;
    pos_r      <= pos_nxt;
    ok_r       <= ok_nxt;
    full_r     <= full_nxt;
    pend_idx_r <= pend_idx_nxt;
    if (cmd.out_load) begin
      succ_r   <= ok_r;
      rej_r    <= full_r;
      ecount_r <= cnt_out(count_r);
      empty_r  <= count_r == '0;
    end
  end

  assign out_success     = succ_r;
  assign out_full_reject = rej_r;
  assign out_entry_count = ecount_r;
  assign out_is_empty    = empty_r;

endmodule

// ===== design/ost_ctrl.sv =====
module ost_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  ost_pkg::stat_t st,
  output ost_pkg::cmd_t  cmd
);
  import ost_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_APPLY = 5'b00100,
    S_SHIFT = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load       = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.walk_run = 1'b1;
        if (st.match || st.walk_idle) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        if (st.need_shift) begin
          cmd.shift_start = 1'b1;
          state_nxt       = S_SHIFT;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_SHIFT: begin
        cmd.walk_run = 1'b1;
        if (st.walk_idle) begin
          cmd.shrink = 1'b1;
          state_nxt  = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/ordered_set_table_top.sv =====
// Add, search, a remove miss or an unused kind go from accept to out_valid through a scan
// of the table, an apply step and a result load.
// Remove of a held value also slides later entries down before the result load.
// Throughput: one word at a time; the next word is taken the cycle after the result loads.
// Reset: sync active-low rst_n clears count and control; table contents stay undefined.
`include "ordered_set_table_top_macros.svh"

module ordered_set_table_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ost_pkg::KIND_W-1:0]      in_kind,
  input  logic signed [ost_pkg::IN_W-1:0] in_elem_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_success,
  output logic                            out_full_reject,
  output logic [ost_pkg::OUT_CNT_W-1:0]   out_entry_count,
  output logic                            out_is_empty
);
  import ost_pkg::*;

  cmd_t  cmd;
  stat_t st;

  ost_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  ost_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_kind         (in_kind),
    .in_elem_value   (in_elem_value),
    .st              (st),
    .out_success     (out_success),
    .out_full_reject (out_full_reject),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty)
  );

  `OST_ASSERT(a_count_in_range, st.count <= CNT_W'(CAPACITY))
  `OST_ASSERT(a_reject_not_ok, !(out_valid && out_full_reject && out_success))
  `OST_ASSERT(a_empty_matches, !out_valid || (out_is_empty == (out_entry_count == '0)))
  `OST_ASSERT_IMP(a_busy_after_accept, in_valid && in_ready, !in_ready)

endmodule
